>>> hdl/asdtf_pkg.sv
// ----------------------------------------------------------------------------
// asdtf_pkg
// Shared types and constants for the audio sample decoder to Q1.31.
// ----------------------------------------------------------------------------
package asdtf_pkg;

    localparam int unsigned IN_W      = 64;
    localparam int unsigned Q_W       = 32;
    localparam int unsigned BITS_W    = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned MANT_W    = 53;
    localparam int unsigned SHIFT_W   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_FORMAT   = 1'b0,
        CFG_BITS_PER_SAMPLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_PCM   = 2'd0,
        FMT_FLOAT = 2'd1,
        FMT_ALAW  = 2'd2,
        FMT_MULAW = 2'd3
    } t_fmt;

    typedef enum logic [2:0] {
        K_PCM8  = 3'd0,
        K_PCM16 = 3'd1,
        K_PCM24 = 3'd2,
        K_PCM32 = 3'd3,
        K_FLOAT = 3'd4,
        K_ALAW  = 3'd5,
        K_MULAW = 3'd6,
        K_UNSUP = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        FC_NORMAL = 2'd0,
        FC_ZERO   = 2'd1,
        FC_SAT    = 2'd2,
        FC_MIN    = 2'd3
    } t_fcls;

    localparam logic [Q_W-1:0] Q_POS_FULL = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_NEG_FULL = 32'h8000_0000;

    typedef struct packed {
        t_kind               kind;
        logic [Q_W-1:0]      raw;
        logic                neg;
        t_fcls               fcls;
        logic [MANT_W-1:0]   mant;
        logic [SHIFT_W-1:0]  shift;
    } t_s1;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           negate;
        logic           sat;
        logic           unsup;
    } t_s2;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           sat;
        logic           unsup;
    } t_res;

endpackage

>>> hdl/asdtf_unpack.sv
// ----------------------------------------------------------------------------
// asdtf_unpack
// First stage: classifies the format and width and splits float fields.
// ----------------------------------------------------------------------------
module asdtf_unpack (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [asdtf_pkg::IN_W-1:0]     i_data,
    input  asdtf_pkg::t_fmt                i_format,
    input  logic [asdtf_pkg::BITS_W-1:0]   i_bits,
    output logic                           o_valid,
    input  logic                           i_ready,
    output asdtf_pkg::t_s1                 o_s1
);

    logic            r_valid;
    asdtf_pkg::t_s1  r_s1;
    asdtf_pkg::t_s1  n_s1;

    logic        is64;
    logic [10:0] expo;
    logic [10:0] emax;
    logic [10:0] bias;
    logic        fracnz;
    logic [11:0] shift_amt;

    always_comb begin
        is64      = (i_bits == 7'd64);
        expo      = is64 ? i_data[62:52] : {3'b000, i_data[30:23]};
        emax      = is64 ? 11'h7FF : 11'h0FF;
        bias      = is64 ? 11'd1023 : 11'd127;
        fracnz    = is64 ? (|i_data[51:0]) : (|i_data[22:0]);
        shift_amt = ({1'b0, bias} + 12'd21) - {1'b0, expo};

        n_s1.raw   = i_data[asdtf_pkg::Q_W-1:0];
        n_s1.neg   = is64 ? i_data[63] : i_data[31];
        n_s1.mant  = is64 ? {1'b1, i_data[51:0]} : {1'b1, i_data[22:0], 29'd0};
        n_s1.shift = (shift_amt > 12'd63) ? 6'd63 : shift_amt[asdtf_pkg::SHIFT_W-1:0];

        if (expo == emax) begin
            n_s1.fcls = fracnz ? asdtf_pkg::FC_ZERO : asdtf_pkg::FC_SAT;
        end else if (expo == 11'd0) begin
            n_s1.fcls = asdtf_pkg::FC_ZERO;
        end else if (expo >= bias) begin
            n_s1.fcls = (n_s1.neg && expo == bias && !fracnz) ? asdtf_pkg::FC_MIN
                                                              : asdtf_pkg::FC_SAT;
        end else begin
            n_s1.fcls = asdtf_pkg::FC_NORMAL;
        end

        unique case (i_format)
            asdtf_pkg::FMT_PCM: begin
                case (i_bits)
                    7'd8:    n_s1.kind = asdtf_pkg::K_PCM8;
                    7'd16:   n_s1.kind = asdtf_pkg::K_PCM16;
                    7'd24:   n_s1.kind = asdtf_pkg::K_PCM24;
                    7'd32:   n_s1.kind = asdtf_pkg::K_PCM32;
                    default: n_s1.kind = asdtf_pkg::K_UNSUP;
                endcase
            end
            asdtf_pkg::FMT_FLOAT: begin
                n_s1.kind = (i_bits == 7'd32 || i_bits == 7'd64) ? asdtf_pkg::K_FLOAT
                                                                  : asdtf_pkg::K_UNSUP;
            end
            asdtf_pkg::FMT_ALAW:  n_s1.kind = asdtf_pkg::K_ALAW;
            asdtf_pkg::FMT_MULAW: n_s1.kind = asdtf_pkg::K_MULAW;
            default:              n_s1.kind = asdtf_pkg::K_UNSUP;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

>>> hdl/asdtf_scale.sv
// ----------------------------------------------------------------------------
// asdtf_scale
// Second stage: aligns PCM, expands G.711 and shifts the float mantissa.
// ----------------------------------------------------------------------------
module asdtf_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  asdtf_pkg::t_s1  i_s1,
    output logic            o_valid,
    input  logic            i_ready,
    output asdtf_pkg::t_s2  o_s2
);

    function automatic logic [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  a;
        logic [2:0]  seg;
        logic [15:0] t;
        a   = code ^ 8'h55;
        seg = a[6:4];
        t   = {8'd0, a[3:0], 4'd0};
        if (seg == 3'd0) begin
            t = t + 16'd8;
        end else begin
            t = (t + 16'h0108) << (seg - 3'd1);
        end
        return a[7] ? t : (16'd0 - t);
    endfunction

    function automatic logic [15:0] mulaw_expand(input logic [7:0] code);
        logic [7:0]  u;
        logic [15:0] t;
        u = ~code;
        t = {9'd0, u[3:0], 3'd0} + 16'h0084;
        t = t << u[6:4];
        return u[7] ? (16'h0084 - t) : (t - 16'h0084);
    endfunction

    logic            r_valid;
    asdtf_pkg::t_s2  r_s2;
    asdtf_pkg::t_s2  n_s2;
    logic [asdtf_pkg::MANT_W-1:0] shifted;

    always_comb begin
        shifted     = i_s1.mant >> i_s1.shift;
        n_s2.q      = '0;
        n_s2.negate = 1'b0;
        n_s2.sat    = 1'b0;
        n_s2.unsup  = 1'b0;
        unique case (i_s1.kind)
            asdtf_pkg::K_PCM8:  n_s2.q = {i_s1.raw[7:0] ^ 8'h80, 24'd0};
            asdtf_pkg::K_PCM16: n_s2.q = {i_s1.raw[15:0], 16'd0};
            asdtf_pkg::K_PCM24: n_s2.q = {i_s1.raw[23:0], 8'd0};
            asdtf_pkg::K_PCM32: n_s2.q = i_s1.raw;
            asdtf_pkg::K_FLOAT: begin
                case (i_s1.fcls)
                    asdtf_pkg::FC_NORMAL: begin
                        n_s2.q      = shifted[asdtf_pkg::Q_W-1:0];
                        n_s2.negate = i_s1.neg;
                    end
                    asdtf_pkg::FC_SAT: begin
                        n_s2.q   = i_s1.neg ? asdtf_pkg::Q_NEG_FULL : asdtf_pkg::Q_POS_FULL;
                        n_s2.sat = 1'b1;
                    end
                    asdtf_pkg::FC_MIN: n_s2.q = asdtf_pkg::Q_NEG_FULL;
                    default:           n_s2.q = '0;
                endcase
            end
            asdtf_pkg::K_ALAW:  n_s2.q = {alaw_expand(i_s1.raw[7:0]), 16'd0};
            asdtf_pkg::K_MULAW: n_s2.q = {mulaw_expand(i_s1.raw[7:0]), 16'd0};
            default:            n_s2.unsup = 1'b1;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

>>> hdl/asdtf_finish.sv
// ----------------------------------------------------------------------------
// asdtf_finish
// Third stage: applies the float sign and holds the result beat.
// ----------------------------------------------------------------------------
module asdtf_finish (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  asdtf_pkg::t_s2   i_s2,
    output logic             o_valid,
    input  logic             i_ready,
    output asdtf_pkg::t_res  o_res
);

    logic             r_valid;
    asdtf_pkg::t_res  r_res;
    asdtf_pkg::t_res  n_res;

    always_comb begin
        n_res.q     = i_s2.negate ? (32'd0 - i_s2.q) : i_s2.q;
        n_res.sat   = i_s2.sat;
        n_res.unsup = i_s2.unsup;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> hdl/audio_sample_decode_to_fixed.sv
// ----------------------------------------------------------------------------
// audio_sample_decode_to_fixed
// Decodes one raw PCM, float or G.711 sample per beat into signed Q1.31.
// An accepted input beat passes through the unpack, scale and finish stage registers to the output beat.
// Throughput is one beat per cycle; each of the three stage registers stalls
// only when it holds a beat that the next stage cannot take.
// Reset clears the stage valid bits and sets format PCM, 16 bits per sample.
// ----------------------------------------------------------------------------
module audio_sample_decode_to_fixed (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asdtf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [asdtf_pkg::BITS_W-1:0]      i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields: sample_bytes[63:0].
    input  logic [asdtf_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields: sample_q31[31:0].
    output logic [asdtf_pkg::Q_W-1:0]         m_axis_tdata,
    // Fields: saturated[0], unsupported[1].
    output logic [1:0]                        m_axis_tuser
);

    asdtf_pkg::t_fmt               r_sample_format;
    logic [asdtf_pkg::BITS_W-1:0]  r_bits_per_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format   <= asdtf_pkg::FMT_PCM;
            r_bits_per_sample <= 7'd16;
        end else if (i_cfg_we) begin
            unique case (asdtf_pkg::t_cfg_idx'(i_cfg_index))
                asdtf_pkg::CFG_SAMPLE_FORMAT:
                    r_sample_format <= asdtf_pkg::t_fmt'(i_cfg_data[1:0]);
                asdtf_pkg::CFG_BITS_PER_SAMPLE:
                    r_bits_per_sample <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic             s1_valid;
    logic             s1_ready;
    asdtf_pkg::t_s1   s1_data;
    logic             s2_valid;
    logic             s2_ready;
    asdtf_pkg::t_s2   s2_data;
    asdtf_pkg::t_res  res;

    asdtf_unpack u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_format (r_sample_format),
        .i_bits   (r_bits_per_sample),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_s1     (s1_data)
    );

    asdtf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2_data)
    );

    asdtf_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = res.q;
    assign m_axis_tuser = {res.unsup, res.sat};

    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("Unsupported beat carries a nonzero sample.");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("Saturated and unsupported flags are both set.");

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata == asdtf_pkg::Q_POS_FULL || m_axis_tdata == asdtf_pkg::Q_NEG_FULL))
        else $error("Saturated beat is not at full scale.");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_valid && !s2_valid && !m_axis_tvalid |-> s_axis_tready)
        else $error("Empty pipeline refuses an input beat.");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for audio_sample_decode_to_fixed. Sample beats are sent
// on the input stream while a local decoder computes the Q1.31 value and flags
// for every accepted beat. Output beats are compared field by field, in
// order, against those predictions. Directed cases cover every format, the
// width extremes and the float corner cases. A backpressure test holds the
// output in one long stall; random phases then change the format and width
// between bursts, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned LONG_HOLD = 200;
    localparam int unsigned PRED_DEPTH = 64;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [asdtf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [asdtf_pkg::BITS_W-1:0]    i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // Fields: sample_bytes[63:0].
    logic [asdtf_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // Fields: sample_q31[31:0].
    logic [asdtf_pkg::Q_W-1:0]       m_axis_tdata;
    // Fields: saturated[0], unsupported[1].
    logic [1:0]                      m_axis_tuser;

    asdtf_pkg::t_fmt   cur_fmt = asdtf_pkg::FMT_PCM;
    logic [6:0]        cur_bits = 7'd16;
    asdtf_pkg::t_res   pred_mem [PRED_DEPTH];
    int unsigned       pred_wr = 0;
    int unsigned       pred_rd = 0;
    int unsigned       mismatch_count = 0;
    bit                tx_gaps_on = 1'b0;
    bit                rx_stalls_on = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_ack = 1'b0;
    int unsigned       rx_wait = 0;
    int unsigned       rx_draw;
    asdtf_pkg::t_res   want_res;

    audio_sample_decode_to_fixed u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // IEEE value times 2^31, truncated toward zero and clamped; bit 32 is the
    // saturation flag.
    function automatic logic [32:0] float_to_q31(input logic neg,
                                                 input int unsigned ebits,
                                                 input longint unsigned frac,
                                                 input int bias, input int fbits,
                                                 input int unsigned emax);
        longint unsigned mant;
        longint unsigned mag;
        int              ue;
        int              sh;
        if (ebits == emax) begin
            if (frac != 0)
                return 33'd0;
            return {1'b1, neg ? asdtf_pkg::Q_NEG_FULL : asdtf_pkg::Q_POS_FULL};
        end
        if (ebits == 0)
            return 33'd0;
        ue = int'(ebits) - bias;
        if (ue >= 0) begin
            if (neg && ue == 0 && frac == 0)
                return {1'b0, asdtf_pkg::Q_NEG_FULL};
            return {1'b1, neg ? asdtf_pkg::Q_NEG_FULL : asdtf_pkg::Q_POS_FULL};
        end
        mant = frac | (64'd1 << fbits);
        sh = ue + 31 - fbits;
        if (sh >= 0)
            mag = mant << sh;
        else if (-sh >= 64)
            mag = 0;
        else
            mag = mant >> (-sh);
        return {1'b0, neg ? (32'd0 - mag[31:0]) : mag[31:0]};
    endfunction

    function automatic logic [15:0] alaw_to_linear(input logic [7:0] code);
        logic [7:0] a;
        int         seg;
        int         t;
        a = code ^ 8'h55;
        seg = int'(a[6:4]);
        t = int'(a[3:0]) << 4;
        if (seg == 0)
            t = t + 8;
        else
            t = (t + 'h108) << (seg - 1);
        if (!a[7])
            t = -t;
        return t[15:0];
    endfunction

    function automatic logic [15:0] mulaw_to_linear(input logic [7:0] code);
        logic [7:0] u;
        int         t;
        u = ~code;
        t = (int'(u[3:0]) << 3) + 'h84;
        t = t << int'(u[6:4]);
        t = u[7] ? ('h84 - t) : (t - 'h84);
        return t[15:0];
    endfunction

    function automatic asdtf_pkg::t_res decode_sample(input asdtf_pkg::t_fmt fmt,
                                                      input logic [6:0] bits,
                                                      input logic [63:0] d);
        asdtf_pkg::t_res r;
        logic [32:0]     fq;
        r = '0;
        case (fmt)
            asdtf_pkg::FMT_PCM: begin
                case (bits)
                    7'd8:    r.q = {d[7:0] ^ 8'h80, 24'h0};
                    7'd16:   r.q = {d[15:0], 16'h0};
                    7'd24:   r.q = {d[23:0], 8'h0};
                    7'd32:   r.q = d[31:0];
                    default: r.unsup = 1'b1;
                endcase
            end
            asdtf_pkg::FMT_FLOAT: begin
                if (bits == 7'd32) begin
                    fq = float_to_q31(d[31], 32'(d[30:23]), 64'(d[22:0]), 127, 23, 255);
                    r.q = fq[31:0];
                    r.sat = fq[32];
                end else if (bits == 7'd64) begin
                    fq = float_to_q31(d[63], 32'(d[62:52]), 64'(d[51:0]), 1023, 52, 2047);
                    r.q = fq[31:0];
                    r.sat = fq[32];
                end else begin
                    r.unsup = 1'b1;
                end
            end
            asdtf_pkg::FMT_ALAW: r.q = {alaw_to_linear(d[7:0]), 16'h0};
            default:             r.q = {mulaw_to_linear(d[7:0]), 16'h0};
        endcase
        return r;
    endfunction

    // Every accepted input beat gives one expected output beat.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pred_mem[pred_wr % PRED_DEPTH] = decode_sample(cur_fmt, cur_bits, s_axis_tdata);
            pred_wr = pred_wr + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pred_wr == pred_rd) begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual q %h user %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want_res = pred_mem[pred_rd % PRED_DEPTH];
                pred_rd = pred_rd + 1;
                if (m_axis_tdata !== want_res.q) begin
                    mismatch_count++;
                    $display("%0t: sample_q31 expected %h actual %h",
                             $time, want_res.q, m_axis_tdata);
                end
                if (m_axis_tuser[0] !== want_res.sat) begin
                    mismatch_count++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, want_res.sat, m_axis_tuser[0]);
                end
                if (m_axis_tuser[1] !== want_res.unsup) begin
                    mismatch_count++;
                    $display("%0t: unsupported expected %b actual %b",
                             $time, want_res.unsup, m_axis_tuser[1]);
                end
            end
        end
    end

    // Output side: short random stalls after some beats when enabled, and a long
    // hold on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            rx_wait <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_wait == 1) begin
            rx_wait <= 0;
            m_axis_tready <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = (rx_stalls_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
            rx_wait <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [63:0] d);
        int unsigned gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pred_wr != pred_rd)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input asdtf_pkg::t_cfg_idx idx, input logic [6:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == asdtf_pkg::CFG_SAMPLE_FORMAT)
            cur_fmt = asdtf_pkg::t_fmt'(val[1:0]);
        else
            cur_bits = val;
    endtask

    task automatic set_format(input asdtf_pkg::t_fmt fmt, input logic [6:0] bits);
        write_reg(asdtf_pkg::CFG_SAMPLE_FORMAT, {5'd0, fmt});
        write_reg(asdtf_pkg::CFG_BITS_PER_SAMPLE, bits);
    endtask

    function automatic logic [63:0] random_single();
        logic [63:0] v;
        int unsigned e;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       e = 0;
            1:       e = 255;
            2:       e = $urandom_range(0, 255);
            default: e = $urandom_range(95, 128);
        endcase
        v[30:23] = e[7:0];
        if ($urandom_range(0, 7) == 0)
            v[22:0] = '0;
        return v;
    endfunction

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        int unsigned e;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       e = 0;
            1:       e = 2047;
            2:       e = $urandom_range(0, 2047);
            default: e = $urandom_range(989, 1024);
        endcase
        v[62:52] = e[10:0];
        if ($urandom_range(0, 7) == 0)
            v[51:0] = '0;
        return v;
    endfunction

    function automatic logic [63:0] random_sample();
        if (cur_fmt == asdtf_pkg::FMT_FLOAT && cur_bits == 7'd64)
            return random_double();
        if (cur_fmt == asdtf_pkg::FMT_FLOAT)
            return random_single();
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_defaults();
        send_sample(64'h0);
        send_sample(64'hFFFF_FFFF_FFFF_7FFF);
        send_sample(64'h8000);
    endtask

    task automatic test_pcm_widths();
        set_format(asdtf_pkg::FMT_PCM, 7'd8);
        send_sample(64'h0);
        send_sample(64'hFF);
        set_format(asdtf_pkg::FMT_PCM, 7'd24);
        send_sample(64'hFFFF_FFFF_FF80_0000);
        send_sample(64'h7F_FFFF);
        set_format(asdtf_pkg::FMT_PCM, 7'd32);
        send_sample(64'h8000_0000);
        send_sample(64'hFFFF_FFFF_7FFF_FFFF);
        set_format(asdtf_pkg::FMT_PCM, 7'd0);
        send_sample(64'h1234_5678_9ABC_DEF0);
        set_format(asdtf_pkg::FMT_PCM, 7'd64);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_float_singles();
        set_format(asdtf_pkg::FMT_FLOAT, 7'd32);
        send_sample(64'h3F80_0000);
        send_sample(64'hBF80_0000);
        send_sample(64'hFFFF_FFFF_FF80_0000);
        send_sample(64'h7FC0_0000);
        send_sample(64'h0000_0001);
        send_sample(64'hBF7F_FFFF);
        send_sample(64'h3F00_0000);
    endtask

    task automatic test_float_doubles();
        set_format(asdtf_pkg::FMT_FLOAT, 7'd64);
        send_sample(64'hBFF0_0000_0000_0000);
        send_sample(64'h7FF0_0000_0000_0000);
        send_sample(64'h3FEF_FFFF_FFFF_FFFF);
        send_sample(64'hFFF8_0000_0000_0000);
        send_sample(64'h3E00_0000_0000_0000);
        write_reg(asdtf_pkg::CFG_BITS_PER_SAMPLE, 7'd16);
        send_sample(64'h3F80_0000);
    endtask

    task automatic test_g711();
        set_format(asdtf_pkg::FMT_ALAW, 7'd0);
        send_sample(64'hFFFF_FFFF_FFFF_FFD5);
        send_sample(64'h2A);
        write_reg(asdtf_pkg::CFG_SAMPLE_FORMAT, {5'd0, asdtf_pkg::FMT_MULAW});
        send_sample(64'hFF);
        send_sample(64'hFFFF_FFFF_FFFF_FF00);
    endtask

    task automatic test_backpressure();
        set_format(asdtf_pkg::FMT_FLOAT, 7'd32);
        tx_gaps_on = 1'b0;
        hold_req <= !hold_req;
        repeat (40) send_sample(random_sample());
        wait_drained();
        tx_gaps_on = 1'b1;
        repeat (20) send_sample(random_sample());
    endtask

    task automatic test_random_phases(input int unsigned phases);
        asdtf_pkg::t_fmt fmt;
        logic [6:0]      bits;
        int unsigned     count;
        repeat (phases) begin
            fmt = asdtf_pkg::t_fmt'(2'($urandom_range(0, 3)));
            case (fmt)
                asdtf_pkg::FMT_PCM: begin
                    case ($urandom_range(0, 3))
                        0:       bits = 7'd8;
                        1:       bits = 7'd16;
                        2:       bits = 7'd24;
                        default: bits = 7'd32;
                    endcase
                end
                asdtf_pkg::FMT_FLOAT: bits = $urandom_range(0, 1) ? 7'd64 : 7'd32;
                default:              bits = 7'($urandom_range(0, 64));
            endcase
            if ($urandom_range(0, 7) == 0)
                bits = 7'($urandom_range(0, 64));
            if ($urandom_range(0, 1)) begin
                write_reg(asdtf_pkg::CFG_BITS_PER_SAMPLE, bits);
                write_reg(asdtf_pkg::CFG_SAMPLE_FORMAT, {5'd0, fmt});
            end else begin
                set_format(fmt, bits);
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on <= ($urandom_range(0, 3) != 0);
            count = $urandom_range(20, 60);
            repeat (count) send_sample(random_sample());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_pcm_widths();
        test_float_singles();
        test_float_doubles();
        test_g711();
        test_backpressure();
        test_random_phases(40);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pred_wr == pred_rd)
            $display("audio_sample_decode_to_fixed: match");
        else
            $display("audio_sample_decode_to_fixed: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("audio_sample_decode_to_fixed: mismatch");
        $finish;
    end

endmodule

>>> files.f
hdl/asdtf_pkg.sv
hdl/asdtf_unpack.sv
hdl/asdtf_scale.sv
hdl/asdtf_finish.sv
hdl/audio_sample_decode_to_fixed.sv
tb/testbench.sv
